@@ hw/rtl/fl_pkg.sv @@
// Shared constants, codes and root table function for the focal loss unit.
`timescale 1ns / 1ps

package fl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_BATCH_DEF = 1024;

    localparam int PROB_W = 17;
    localparam int GAMMA_W = 16;
    localparam int ALPHA_W = 17;
    localparam int LOSS_W = 20;
    localparam int GRAD_W = 22;
    localparam int BCNT_W = 32;
    localparam int CFG_W = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'd1;

    localparam logic [GAMMA_W-1:0] GAMMA_RST = 16'd8192;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd16384;
    localparam logic [GAMMA_W-1:0] GAMMA_MAX = 16'd32768;
    localparam logic [ALPHA_W-1:0] ONE_FX = 17'd65536;
    localparam logic [LOSS_W-1:0] LOSS_MAX = 20'd786432;
    localparam logic [29:0] SUM_MAX = 30'h3FFF_FFFF;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Floor integer square root, elaboration use only.
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bt;
        n = n_in;
        res = 64'd0;
        bt = 64'h4000_0000_0000_0000;
        while (bt > n) bt = bt >> 2;
        while (bt != 64'd0) begin
            if (n >= res + bt) begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // 2^-(2^-k) in Q0.30, by repeated square roots of one half.
    function automatic logic [30:0] root_q30(input int k);
        logic [63:0] r;
        r = 64'd1 << 29;
        for (int j = 1; j <= k; j++) r = isqrt64(r << 30);
        return r[30:0];
    endfunction

endpackage

@@ hw/rtl/fl_in_if.sv @@
// Input sample channel of the focal loss unit.
`timescale 1ns / 1ps

interface fl_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [fl_pkg::PROB_W-1:0]     prob_q16;
    logic                          target_bit;
    logic                          class_in_range;
    logic                          last_in_batch;

    modport source (output valid, op, prob_q16, target_bit, class_in_range, last_in_batch,
                    input ready);
    modport sink (input valid, op, prob_q16, target_bit, class_in_range, last_in_batch,
                  output ready);
endinterface

@@ hw/rtl/fl_out_if.sv @@
// Result channel of the focal loss unit.
`timescale 1ns / 1ps

interface fl_out_if;
    logic                                valid;
    logic                                ready;
    logic [fl_pkg::LOSS_W-1:0]           loss_q16;
    logic signed [fl_pkg::GRAD_W-1:0]    grad_q16;
    logic [fl_pkg::LOSS_W-1:0]           batch_mean_q16;
    logic                                mean_valid;
    logic [fl_pkg::BCNT_W-1:0]           batches_done;

    modport source (output valid, loss_q16, grad_q16, batch_mean_q16, mean_valid,
                    batches_done, input ready);
    modport sink (input valid, loss_q16, grad_q16, batch_mean_q16, mean_valid,
                  batches_done, output ready);
endinterface

@@ hw/rtl/focal_loss_unit.sv @@
// Focal loss unit: per-sample loss and gradient plus batch mean on one shared multiplier.
//
//   channel   dir   handshake        contents
//   i_in      in    valid/ready      op, prob_q16, target_bit, class_in_range, last_in_batch
//   o_out     out   valid/ready      loss_q16, grad_q16, batch_mean_q16, mean_valid, batches_done
//   i_cfg_*   in    write enable     gamma_q12 (index 0), alpha_q16 (index 1)
//
// Each sample steps through the sequencer states from acceptance to result; when the focusing
// weight underflows to zero the root products are skipped, and the batch mean adds a 31-step
// restoring divider on the last sample of a batch. The 32x32 multiplier does the products:
// 2x16 squarings for the two logarithms, 16 root products for the power, seven scaling products.
// i_in.ready is high only while the sequencer is idle; a finished result waits in the
// output register, and a second one holds the sequencer until that register drains.
// Synchronous active-low reset clears the sequencer, sums and counters and loads the configuration defaults.
`timescale 1ns / 1ps

module focal_loss_unit #(
    parameter int MAX_BATCH = fl_pkg::MAX_BATCH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fl_pkg::CFG_W-1:0]       i_cfg_data,
    fl_in_if.sink                          i_in,
    fl_out_if.source                       o_out
);

    localparam int F = fl_pkg::FRAC_BITS;
    localparam int CW = $clog2(MAX_BATCH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_NLN  = 4'd3;
    localparam logic [3:0] S_EXP  = 4'd4;
    localparam logic [3:0] S_POW  = 4'd5;
    localparam logic [3:0] S_WSH  = 4'd6;
    localparam logic [3:0] S_AW   = 4'd7;
    localparam logic [3:0] S_LOSS = 4'd8;
    localparam logic [3:0] S_PN   = 4'd9;
    localparam logic [3:0] S_GT   = 4'd10;
    localparam logic [3:0] S_MAG  = 4'd11;
    localparam logic [3:0] S_ACC  = 4'd12;
    localparam logic [3:0] S_DIV  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [30:0] w_root [F];
    for (genvar k = 0; k < F; k++) begin : g_root
        assign w_root[k] = fl_pkg::root_q30(k + 1);
    end

    // control
    logic [3:0]  r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_phase, n_phase;
    logic [15:0] r_gamma, n_gamma;
    logic [16:0] r_alpha, n_alpha;
    logic [29:0] r_sum, n_sum;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_bc, n_bc;
    logic        r_ov, n_ov;

    // payload
    logic        r_op, n_op, r_tbit, n_tbit, r_cir, n_cir, r_last, n_last;
    logic [15:0] r_pt, n_pt, r_q, n_q, r_x, n_x;
    logic [16:0] r_at, n_at, r_g, n_g;
    logic [31:0] r_y, n_y;
    logic [4:0]  r_lb, n_lb;
    logic [15:0] r_frac, n_frac;
    logic [20:0] r_lpt, n_lpt, r_lq, n_lq;
    logic [19:0] r_nln, n_nln, r_pn, n_pn;
    logic [23:0] r_e, n_e, r_tmag, n_tmag;
    logic [30:0] r_acc, n_acc;
    logic [16:0] r_w, n_w, r_aw, n_aw;
    logic [19:0] r_loss, n_loss;
    logic        r_neg, n_neg;
    logic [21:0] r_grad, n_grad;
    logic [30:0] r_dvd, n_dvd;
    logic [CW-1:0] r_dvs, n_dvs, r_rem, n_rem;
    logic [19:0] r_oloss, n_oloss, r_omean, n_omean;
    logic [21:0] r_ograd, n_ograd;
    logic        r_omv, n_omv;
    logic [31:0] r_obc, n_obc;

    // shared multiplier
    logic [31:0] m_a, m_b;
    logic [63:0] m_p;

    logic [16:0] c_p;
    logic [4:0]  c_b;
    logic [20:0] c_l;
    logic [31:0] c_y2;
    logic [4:0]  c_sh;
    logic [31:0] c_wsum;
    logic [63:0] c_rnd16;
    logic [20:0] c_lraw;
    logic [24:0] c_mag;
    logic [30:0] c_sum;
    logic [CW-1:0] c_cnt, c_n;
    logic [CW:0] c_rs;

    always_comb begin
        m_a = 32'd0;
        m_b = 32'd0;
        case (r_state)
            S_SQ: begin
                m_a = r_y;
                m_b = r_y;
            end
            S_NLN: begin
                m_a = 32'(r_lpt);
                m_b = 32'(fl_pkg::LN2_Q30);
            end
            S_EXP: begin
                m_a = 32'(r_g);
                m_b = 32'(r_lq);
            end
            S_POW: begin
                m_a = 32'(r_acc);
                m_b = 32'(w_root[r_cnt[3:0]]);
            end
            S_AW: begin
                m_a = 32'(r_at);
                m_b = 32'(r_w);
            end
            S_LOSS: begin
                m_a = 32'(r_aw);
                m_b = 32'(r_nln);
            end
            S_PN: begin
                m_a = 32'(r_nln);
                m_b = 32'(r_pt);
            end
            S_GT: begin
                m_a = 32'(r_g);
                m_b = 32'(r_pn);
            end
            S_MAG: begin
                m_a = 32'(r_aw);
                m_b = 32'(r_tmag);
            end
            default: begin
                m_a = 32'd0;
                m_b = 32'd0;
            end
        endcase
    end

    assign m_p = 64'(m_a) * 64'(m_b);
    assign c_rnd16 = m_p + 64'd32768;

    always_comb begin
        c_p = i_in.prob_q16;
        if (c_p < 17'd1) c_p = 17'd1;
        if (c_p > fl_pkg::ONE_FX - 17'd1) c_p = fl_pkg::ONE_FX - 17'd1;

        c_b = 5'd0;
        for (int i = 0; i < F; i++) begin
            if (r_x[i]) c_b = 5'(i);
        end

        c_y2 = m_p[61:30];
        c_l = {r_lb, 16'd0} - 21'(r_frac);
        c_sh = r_e[20:16] + 5'd14;
        c_wsum = 32'(r_acc) + (32'd1 << (c_sh - 5'd1));
        c_lraw = c_rnd16[36:16];
        c_mag = c_rnd16[40:16];

        c_sum = 31'(r_sum) + 31'(r_loss);
        c_cnt = r_count;
        if (r_count < CW'(MAX_BATCH)) begin
            c_cnt = r_count + CW'(1);
            if (c_sum > 31'(fl_pkg::SUM_MAX)) c_sum = 31'(fl_pkg::SUM_MAX);
        end else begin
            c_sum = 31'(r_sum);
        end
        c_n = (c_cnt == '0) ? CW'(1) : c_cnt;
        c_rs = {r_rem, r_dvd[30]};
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_phase = r_phase;
        n_gamma = r_gamma;
        n_alpha = r_alpha;
        n_sum = r_sum;
        n_count = r_count;
        n_bc = r_bc;
        n_ov = r_ov;
        n_op = r_op;
        n_tbit = r_tbit;
        n_cir = r_cir;
        n_last = r_last;
        n_pt = r_pt;
        n_q = r_q;
        n_x = r_x;
        n_at = r_at;
        n_g = r_g;
        n_y = r_y;
        n_lb = r_lb;
        n_frac = r_frac;
        n_lpt = r_lpt;
        n_lq = r_lq;
        n_nln = r_nln;
        n_pn = r_pn;
        n_e = r_e;
        n_tmag = r_tmag;
        n_acc = r_acc;
        n_w = r_w;
        n_aw = r_aw;
        n_loss = r_loss;
        n_neg = r_neg;
        n_grad = r_grad;
        n_dvd = r_dvd;
        n_dvs = r_dvs;
        n_rem = r_rem;
        n_oloss = r_oloss;
        n_omean = r_omean;
        n_ograd = r_ograd;
        n_omv = r_omv;
        n_obc = r_obc;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                fl_pkg::CFG_GAMMA: n_gamma = i_cfg_data[15:0];
                fl_pkg::CFG_ALPHA: n_alpha = i_cfg_data;
                default: ;
            endcase
        end

        if (r_ov && o_out.ready) n_ov = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op = i_in.op;
                    n_tbit = i_in.target_bit;
                    n_cir = i_in.class_in_range;
                    n_last = i_in.last_in_batch;
                    n_g = (r_gamma > fl_pkg::GAMMA_MAX) ? 17'(fl_pkg::GAMMA_MAX)
                                                        : 17'(r_gamma);
                    if (!i_in.op && !i_in.target_bit) begin
                        n_pt = 16'(fl_pkg::ONE_FX - c_p);
                    end else begin
                        n_pt = c_p[15:0];
                    end
                    if (i_in.op) begin
                        n_at = fl_pkg::ONE_FX;
                    end else if (i_in.target_bit) begin
                        n_at = (r_alpha > fl_pkg::ONE_FX) ? fl_pkg::ONE_FX : r_alpha;
                    end else begin
                        n_at = (r_alpha > fl_pkg::ONE_FX) ? 17'd0
                                                          : fl_pkg::ONE_FX - r_alpha;
                    end
                    n_x = n_pt;
                    n_q = 16'(fl_pkg::ONE_FX - 17'(n_pt));
                    n_phase = 1'b0;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_y = 32'(r_x) << (5'd30 - c_b);
                n_lb = 5'(F) - c_b;
                n_frac = 16'd0;
                n_cnt = 5'd0;
                n_state = S_SQ;
            end
            S_SQ: begin
                if (c_y2[31]) begin
                    n_y = c_y2 >> 1;
                    n_frac = {r_frac[14:0], 1'b1};
                end else begin
                    n_y = c_y2;
                    n_frac = {r_frac[14:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(F - 1)) begin
                    // finish the log on the next cycle from the completed fraction
                    n_state = S_SQ;
                    n_cnt = 5'd16;
                end
                if (r_cnt == 5'd16) begin
                    n_y = r_y;
                    n_frac = r_frac;
                    if (!r_phase) begin
                        n_lpt = c_l;
                        n_x = r_q;
                        n_phase = 1'b1;
                        n_state = S_NORM;
                    end else begin
                        n_lq = c_l;
                        n_state = S_NLN;
                    end
                end
            end
            S_NLN: begin
                n_nln = 20'((m_p + 64'd536870912) >> 30);
                n_state = S_EXP;
            end
            S_EXP: begin
                n_e = 24'((m_p + 64'd2048) >> 12);
                n_acc = 31'h4000_0000;
                n_cnt = 5'd0;
                if (n_e[23:16] > 8'(F)) begin
                    n_w = 17'd0;
                    n_state = S_AW;
                end else begin
                    n_state = S_POW;
                end
            end
            S_POW: begin
                if (r_e[4'(F - 1) - r_cnt[3:0]]) n_acc = m_p[60:30];
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(F - 1)) n_state = S_WSH;
            end
            S_WSH: begin
                n_w = 17'(c_wsum >> c_sh);
                n_state = S_AW;
            end
            S_AW: begin
                n_aw = c_rnd16[32:16];
                n_state = S_LOSS;
            end
            S_LOSS: begin
                if (r_op && !r_cir) begin
                    n_loss = 20'd0;
                end else if (c_lraw > 21'(fl_pkg::LOSS_MAX)) begin
                    n_loss = fl_pkg::LOSS_MAX;
                end else begin
                    n_loss = c_lraw[19:0];
                end
                n_state = S_PN;
            end
            S_PN: begin
                n_pn = c_rnd16[35:16];
                n_state = S_GT;
            end
            S_GT: begin
                n_e = 24'((m_p + 64'd2048) >> 12);
                if (n_e > 24'(r_q)) begin
                    n_tmag = n_e - 24'(r_q);
                    n_neg = !r_tbit;
                end else begin
                    n_tmag = 24'(r_q) - n_e;
                    n_neg = r_tbit;
                end
                n_state = S_MAG;
            end
            S_MAG: begin
                if (r_op) begin
                    n_grad = 22'd0;
                end else if (r_neg) begin
                    n_grad = 22'(25'd0 - c_mag);
                end else begin
                    n_grad = c_mag[21:0];
                end
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_last) begin
                    n_dvd = c_sum + 31'(c_n >> 1);
                    n_dvs = c_n;
                    n_rem = '0;
                    n_cnt = 5'd0;
                    n_sum = 30'd0;
                    n_count = '0;
                    n_bc = r_bc + 32'd1;
                    n_state = S_DIV;
                end else begin
                    n_sum = c_sum[29:0];
                    n_count = c_cnt;
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (c_rs >= {1'b0, r_dvs}) begin
                    n_rem = CW'(c_rs - {1'b0, r_dvs});
                    n_dvd = {r_dvd[29:0], 1'b1};
                end else begin
                    n_rem = c_rs[CW-1:0];
                    n_dvd = {r_dvd[29:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd30) n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ov || o_out.ready) begin
                    n_oloss = r_loss;
                    n_ograd = r_grad;
                    n_omv = r_last;
                    n_obc = r_bc;
                    if (!r_last) begin
                        n_omean = 20'd0;
                    end else if (r_dvd > 31'(fl_pkg::LOSS_MAX)) begin
                        n_omean = fl_pkg::LOSS_MAX;
                    end else begin
                        n_omean = r_dvd[19:0];
                    end
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= 5'd0;
            r_phase <= 1'b0;
            r_gamma <= fl_pkg::GAMMA_RST;
            r_alpha <= fl_pkg::ALPHA_RST;
            r_sum <= 30'd0;
            r_count <= '0;
            r_bc <= 32'd0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_phase <= n_phase;
            r_gamma <= n_gamma;
            r_alpha <= n_alpha;
            r_sum <= n_sum;
            r_count <= n_count;
            r_bc <= n_bc;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_tbit <= n_tbit;
        r_cir <= n_cir;
        r_last <= n_last;
        r_pt <= n_pt;
        r_q <= n_q;
        r_x <= n_x;
        r_at <= n_at;
        r_g <= n_g;
        r_y <= n_y;
        r_lb <= n_lb;
        r_frac <= n_frac;
        r_lpt <= n_lpt;
        r_lq <= n_lq;
        r_nln <= n_nln;
        r_pn <= n_pn;
        r_e <= n_e;
        r_tmag <= n_tmag;
        r_acc <= n_acc;
        r_w <= n_w;
        r_aw <= n_aw;
        r_loss <= n_loss;
        r_neg <= n_neg;
        r_grad <= n_grad;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
        r_oloss <= n_oloss;
        r_omean <= n_omean;
        r_ograd <= n_ograd;
        r_omv <= n_omv;
        r_obc <= n_obc;
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.loss_q16 = r_oloss;
    assign o_out.grad_q16 = r_ograd;
    assign o_out.batch_mean_q16 = r_omean;
    assign o_out.mean_valid = r_omv;
    assign o_out.batches_done = r_obc;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the focal loss unit: bit-true loss, gradient, batch mean, mean flag and batch count.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic                      op;
        logic [fl_pkg::PROB_W-1:0] prob;
        logic                      tbit;
        logic                      cir;
        logic                      last;
    } t_sample;

    typedef struct packed {
        logic [fl_pkg::LOSS_W-1:0] loss;
        logic [fl_pkg::GRAD_W-1:0] grad;
        logic [fl_pkg::LOSS_W-1:0] mean;
        logic                      mean_valid;
        logic [fl_pkg::BCNT_W-1:0] batches;
    } t_loss_res;

    class loss_scoreboard;
        bit [63:0]  gamma_reg;
        bit [63:0]  alpha_reg;
        bit [63:0]  loss_acc;
        bit [63:0]  held_count;
        bit [31:0]  batch_cnt;
        bit [63:0]  half_roots[1:16];
        t_loss_res  expected_q[$];
        int         errors;

        function new();
            bit [63:0] r;
            gamma_reg = 64'(fl_pkg::GAMMA_RST);
            alpha_reg = 64'(fl_pkg::ALPHA_RST);
            loss_acc = 0;
            held_count = 0;
            batch_cnt = 0;
            errors = 0;
            r = 64'd1 << 29;
            for (int i = 1; i <= 16; i++) begin
                r = int_sqrt(r << 30);
                half_roots[i] = r;
            end
        endfunction

        function bit [63:0] int_sqrt(bit [63:0] n);
            bit [63:0] res;
            bit [63:0] bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > n) bt = bt >> 2;
            while (bt != 0) begin
                if (n >= res + bt) begin
                    n = n - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            return res;
        endfunction

        // -log2(x / 2^16) in Q.16
        function bit [63:0] minus_log2(bit [63:0] x);
            int b;
            bit [63:0] y;
            bit [63:0] frac;
            b = 0;
            frac = 0;
            while (b < 63 && (x >> (b + 1)) != 0) b++;
            y = x << (30 - b);
            for (int i = 0; i < 16; i++) begin
                y = (y * y) >> 30;
                frac = frac << 1;
                if (y >= (64'd2 << 30)) begin
                    y = y >> 1;
                    frac = frac | 1;
                end
            end
            return (64'(16 - b) << 16) - frac;
        endfunction

        function bit [63:0] focus_weight(bit [63:0] x, bit [63:0] g);
            bit [63:0] e;
            bit [63:0] ip;
            bit [63:0] f;
            bit [63:0] acc;
            int sh;
            e = (g * minus_log2(x) + 2048) >> 12;
            ip = e >> 16;
            f = e & 64'hFFFF;
            if (ip > 16) return 0;
            acc = 64'd1 << 30;
            for (int i = 1; i <= 16; i++)
                if ((f >> (16 - i)) & 1) acc = (acc * half_roots[i]) >> 30;
            sh = int'(ip) + 14;
            return (acc + (64'd1 << (sh - 1))) >> sh;
        endfunction

        function void write_reg(logic [fl_pkg::CFG_IDX_W-1:0] idx,
                                logic [fl_pkg::CFG_W-1:0] val);
            if (idx == fl_pkg::CFG_GAMMA) gamma_reg = 64'(val) & 64'hFFFF;
            else if (idx == fl_pkg::CFG_ALPHA) alpha_reg = 64'(val) & 64'h1FFFF;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_sample(t_sample s);
            bit [63:0] g, a, p, pt, at, q, nln, w, aw, loss, pn, gt, tmag, mag, n;
            bit tneg;
            t_loss_res r;
            g = gamma_reg > 32768 ? 64'd32768 : gamma_reg;
            a = alpha_reg > 65536 ? 64'd65536 : alpha_reg;
            p = 64'(s.prob);
            if (p < 1) p = 1;
            if (p > 65535) p = 65535;
            if (s.op == 1'b0) begin
                pt = s.tbit ? p : 65536 - p;
                at = s.tbit ? a : 65536 - a;
            end else begin
                pt = p;
                at = 65536;
            end
            q = 65536 - pt;
            nln = (minus_log2(pt) * 64'(fl_pkg::LN2_Q30) + (64'd1 << 29)) >> 30;
            w = focus_weight(q, g);
            aw = (at * w + 32768) >> 16;
            loss = (aw * nln + 32768) >> 16;
            if (s.op == 1'b1 && s.cir == 1'b0) loss = 0;
            if (loss > 64'(fl_pkg::LOSS_MAX)) loss = 64'(fl_pkg::LOSS_MAX);
            r = '0;
            r.loss = loss[fl_pkg::LOSS_W-1:0];
            if (s.op == 1'b0) begin
                pn = (nln * pt + 32768) >> 16;
                gt = (g * pn + 2048) >> 12;
                tneg = gt > q;
                tmag = tneg ? gt - q : q - gt;
                mag = (aw * tmag + 32768) >> 16;
                r.grad = ((s.tbit == 1'b1) != tneg) ? fl_pkg::GRAD_W'(-mag)
                                                     : fl_pkg::GRAD_W'(mag);
            end
            if (held_count < 1024) begin
                loss_acc = loss_acc + loss;
                if (loss_acc > 64'(fl_pkg::SUM_MAX)) loss_acc = 64'(fl_pkg::SUM_MAX);
                held_count++;
            end
            if (s.last) begin
                n = held_count != 0 ? held_count : 1;
                n = (loss_acc + n / 2) / n;
                if (n > 64'(fl_pkg::LOSS_MAX)) n = 64'(fl_pkg::LOSS_MAX);
                r.mean = n[fl_pkg::LOSS_W-1:0];
                r.mean_valid = 1'b1;
                batch_cnt++;
                loss_acc = 0;
                held_count = 0;
            end
            r.batches = batch_cnt;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_loss_res got);
            t_loss_res exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.loss !== exp_r.loss) begin
                errors++;
                $display("%0t: loss exp %0d got %0d", $time, exp_r.loss, got.loss);
            end
            if (got.grad !== exp_r.grad) begin
                errors++;
                $display("%0t: grad exp %h got %h", $time, exp_r.grad, got.grad);
            end
            if (got.mean !== exp_r.mean) begin
                errors++;
                $display("%0t: batch mean exp %0d got %0d", $time, exp_r.mean, got.mean);
            end
            if (got.mean_valid !== exp_r.mean_valid) begin
                errors++;
                $display("%0t: mean_valid exp %b got %b", $time, exp_r.mean_valid,
                         got.mean_valid);
            end
            if (got.batches !== exp_r.batches) begin
                errors++;
                $display("%0t: batches exp %0d got %0d", $time, exp_r.batches, got.batches);
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [fl_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [fl_pkg::CFG_W-1:0]     i_cfg_data;

    fl_in_if  in_if();
    fl_out_if out_if();

    focal_loss_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    loss_scoreboard sb = new();
    bit no_idle = 0;
    bit hold_req = 0;
    bit in_reset_done = 0;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = fl_pkg::CFG_GAMMA;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.op = 1'b0;
        in_if.prob_q16 = '0;
        in_if.target_bit = 1'b0;
        in_if.class_in_range = 1'b0;
        in_if.last_in_batch = 1'b0;
        out_if.ready = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic send_sample(logic op, logic [fl_pkg::PROB_W-1:0] p, logic t, logic c,
                               logic last);
        int gap;
        t_sample s;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.op <= op;
        in_if.prob_q16 <= p;
        in_if.target_bit <= t;
        in_if.class_in_range <= c;
        in_if.last_in_batch <= last;
        s = '{op: op, prob: p, tbit: t, cir: c, last: last};
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_sample(s);
    endtask

    // drop valid and hold until every result is back
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [fl_pkg::CFG_IDX_W-1:0] idx, logic [fl_pkg::CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [fl_pkg::PROB_W-1:0] rand_prob();
        logic [fl_pkg::PROB_W-1:0] corner[7] = '{0, 1, 2, 65534, 65535, 65536, 131071};
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return corner[$urandom_range(0, 6)];
        if (sel == 1) return fl_pkg::PROB_W'($urandom_range(0, 131071));
        if (sel == 2) return fl_pkg::PROB_W'($urandom_range(0, 1023));
        if (sel == 3) return fl_pkg::PROB_W'($urandom_range(64512, 65536));
        return fl_pkg::PROB_W'($urandom_range(1, 65535));
    endfunction

    task automatic random_batchy(int count, int last_odds);
        for (int i = 0; i < count; i++)
            send_sample(1'($urandom_range(0, 1)), rand_prob(), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) != 0, $urandom_range(0, last_odds - 1) == 0);
    endtask

    // result side: random stall after each transaction, plus one long hold-off
    initial begin
        int stall;
        int hold;
        stall = 0;
        hold = 0;
        wait (in_reset_done);
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                sb.check_result('{loss: out_if.loss_q16, grad: out_if.grad_q16,
                                  mean: out_if.batch_mean_q16, mean_valid: out_if.mean_valid,
                                  batches: out_if.batches_done});
                stall = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (hold_req) begin
                hold_req = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [fl_pkg::PROB_W-1:0] dprob[6] = '{0, 1, 32768, 65535, 65536, 131071};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_reset_done = 1;

        // reset configuration: extremes of probability over both modes and labels
        foreach (dprob[k]) begin
            send_sample(1'b0, dprob[k], 1'b1, 1'b0, 1'b0);
            send_sample(1'b0, dprob[k], 1'b0, 1'b1, 1'b0);
            send_sample(1'b1, dprob[k], k[0], 1'b1, 1'b0);
        end
        send_sample(1'b1, 17'd30000, 1'b1, 1'b0, 1'b1);  // class out of range
        send_sample(1'b1, 17'd100, 1'b0, 1'b0, 1'b1);    // single-sample batch, zero loss
        send_sample(1'b0, 17'd5, 1'b1, 1'b1, 1'b1);
        drain();

        write_cfg(fl_pkg::CFG_GAMMA, 17'd0);
        write_cfg(fl_pkg::CFG_ALPHA, 17'd0);
        random_batchy(70, 8);
        drain();

        write_cfg(fl_pkg::CFG_GAMMA, 17'd32768);
        write_cfg(fl_pkg::CFG_ALPHA, 17'd65536);
        no_idle = 1;
        random_batchy(70, 6);
        no_idle = 0;
        drain();

        // above range: both saturate
        write_cfg(fl_pkg::CFG_GAMMA, 17'h0FFFF);
        write_cfg(fl_pkg::CFG_ALPHA, 17'h1FFFF);
        random_batchy(70, 10);
        drain();

        write_cfg(fl_pkg::CFG_GAMMA, fl_pkg::CFG_W'($urandom_range(0, 32768)));
        write_cfg(fl_pkg::CFG_ALPHA, fl_pkg::CFG_W'($urandom_range(0, 65536)));
        random_batchy(70, 8);
        drain();

        // one batch longer than the limit; result side holds off early on
        write_cfg(fl_pkg::CFG_GAMMA, 17'd4096);
        write_cfg(fl_pkg::CFG_ALPHA, 17'd49152);
        hold_req = 1;
        random_batchy(1060, 1000000);
        send_sample(1'b0, rand_prob(), 1'b1, 1'b1, 1'b1);
        drain();

        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/fl_pkg.sv
hw/rtl/fl_in_if.sv
hw/rtl/fl_out_if.sv
hw/rtl/focal_loss_unit.sv
tb/tb_top.sv
